@@ rtl/gvfm_pkg.sv @@
// Shared types and constants for the greedy voxel face mesher.
// No dependencies; imported by every file except gvfm_ram.
package gvfm_pkg;

    localparam int MaxDim     = 32;
    localparam int Side       = MaxDim + 2;
    localparam int StoreDepth = Side * Side * Side;
    localparam int DimW       = $clog2(MaxDim + 1) + 1;
    localparam int CoordW     = $clog2(MaxDim);
    localparam int StoreAw    = $clog2(StoreDepth);
    localparam int MaskAw     = 2 * CoordW;
    localparam int CellW      = 17;
    localparam int CodeW      = 18;

    localparam logic [1:0] RegDimX = 2'd0;
    localparam logic [1:0] RegDimY = 2'd1;
    localparam logic [1:0] RegDimZ = 2'd2;

    localparam logic CmdWrite   = 1'b0;
    localparam logic CmdRequest = 1'b1;

    // Command strobes from the controller to the datapath.
    typedef struct packed {
        logic cell_wr;
        logic build_init;
        logic lo_rd;
        logic hi_rd;
        logic b_wr;
        logic mask_done;
        logic find_init;
        logic f_rd;
        logic row_next;
        logic col_next;
        logic code_latch;
        logic w_rd;
        logic w_inc;
        logic h_init;
        logic h_rd;
        logic h_next_row;
        logic k_inc;
        logic clr_init;
        logic clr_wr;
        logic slice_next;
        logic out_quad;
        logic out_done;
    } t_cmd;

    typedef struct packed {
        logic finished;
        logic mask_ready;
        logic row_end;
        logic col_end;
        logic code_zero;
        logic w_can;
        logic code_eq;
        logic h_can;
        logic k_last;
        logic clr_last;
    } t_sts;

endpackage

@@ rtl/gvfm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gvfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/gvfm_dp.sv @@
// Datapath of the mesher: dimension registers, scan cursor, cell store and face mask.
// Depends on gvfm_pkg and gvfm_ram.
module gvfm_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gvfm_pkg::t_cmd     i_cmd,
    output gvfm_pkg::t_sts     o_sts,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [5:0]         i_cfg_data,
    input  logic [6:0]         i_pos_x,
    input  logic [6:0]         i_pos_y,
    input  logic [6:0]         i_pos_z,
    input  logic               i_cell_solid,
    input  logic [7:0]         i_cell_id,
    input  logic [7:0]         i_cell_shade,
    output logic               o_quad_valid,
    output logic [1:0]         o_axis,
    output logic               o_facing_positive,
    output logic [5:0]         o_slice,
    output logic [4:0]         o_start_u,
    output logic [4:0]         o_start_v,
    output logic [5:0]         o_width,
    output logic [5:0]         o_height,
    output logic [7:0]         o_face_id,
    output logic [7:0]         o_face_shade,
    output logic               o_done_res
);
    import gvfm_pkg::*;

    logic [DimW-1:0] r_dim [3];
    logic [1:0]      r_axis;
    logic [DimW-1:0] r_slice, r_row, r_col;
    logic            r_mready, r_fin;
    logic [DimW-1:0] r_j, r_i, r_w, r_h, r_k, r_t;
    logic [CellW-1:0] r_lo;
    logic [CodeW-1:0] r_code;

    logic [DimW-1:0] su, sv, sd, cfg_dim;
    logic [1:0]      ax_u, ax_v;
    logic            restart;

    logic [7:0] wx, wy, wz;
    logic       w_in_range;
    logic [StoreAw-1:0] cell_waddr, cell_raddr;
    logic [CellW-1:0]   cell_rdata;
    logic [DimW-1:0]    qa, qb, qc, cx, cy, cz;

    logic [MaskAw-1:0] m_raddr, m_waddr;
    logic              m_we;
    logic [CodeW-1:0]  m_wdata, m_rdata, b_code;
    logic [DimW-1:0]   iw, ik, jh, jt;
    logic [15:0]       mag;

    assign ax_u = (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
    assign ax_v = (r_axis == 2'd0) ? 2'd2 : r_axis - 2'd1;
    assign su   = r_dim[ax_u];
    assign sv   = r_dim[ax_v];
    assign sd   = r_dim[r_axis];

    assign cfg_dim = (i_cfg_data == '0) ? DimW'(1) :
                     (i_cfg_data > 6'(MaxDim)) ? DimW'(MaxDim) : DimW'(i_cfg_data);
    assign restart = i_cmd.cell_wr || (i_cfg_we && i_cfg_index != 2'd3);

    // Cell store write: coordinates shift by one to cover the border.
    assign wx = {i_pos_x[6], i_pos_x} + 8'd1;
    assign wy = {i_pos_y[6], i_pos_y} + 8'd1;
    assign wz = {i_pos_z[6], i_pos_z} + 8'd1;
    assign w_in_range = !wx[7] && !wy[7] && !wz[7] &&
                        wx <= 8'(Side - 1) && wy <= 8'(Side - 1) && wz <= 8'(Side - 1);
    assign cell_waddr = StoreAw'(wx) * StoreAw'(Side * Side) +
                        StoreAw'(wy) * StoreAw'(Side) + StoreAw'(wz);

    // Read address: normal coordinate is slice for the low cell, slice+1 for the high one.
    assign qa = i_cmd.hi_rd ? r_slice + DimW'(1) : r_slice;
    assign qb = r_i + DimW'(1);
    assign qc = r_j + DimW'(1);
    always_comb begin
        case (r_axis)
            2'd0: begin
                cx = qa; cy = qb; cz = qc;
            end
            2'd1: begin
                cy = qa; cz = qb; cx = qc;
            end
            default: begin
                cz = qa; cx = qb; cy = qc;
            end
        endcase
    end
    assign cell_raddr = StoreAw'(cx) * StoreAw'(Side * Side) +
                        StoreAw'(cy) * StoreAw'(Side) + StoreAw'(cz);

    gvfm_ram #(.WIDTH(CellW), .DEPTH(StoreDepth)) u_cells (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cell_wr && w_in_range),
        .i_waddr (cell_waddr),
        .i_wdata ({i_cell_solid, i_cell_id, i_cell_shade}),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    // Face code of the current cell pair; cell_rdata holds the high cell.
    always_comb begin
        b_code = '0;
        if (r_lo[16] && !cell_rdata[16] && r_slice != '0) begin
            b_code = {2'b00, r_lo[15:0]} + CodeW'(1);
        end else if (cell_rdata[16] && !r_lo[16] && r_slice < sd) begin
            b_code = ~({2'b00, cell_rdata[15:0]} + CodeW'(1)) + CodeW'(1);
        end
    end

    assign iw = r_i + r_w;
    assign ik = r_i + r_k;
    assign jh = r_j + r_h;
    assign jt = r_j + r_t;

    always_comb begin
        if (i_cmd.w_rd) begin
            m_raddr = {r_j[CoordW-1:0], iw[CoordW-1:0]};
        end else if (i_cmd.h_rd) begin
            m_raddr = {jh[CoordW-1:0], ik[CoordW-1:0]};
        end else begin
            m_raddr = {r_j[CoordW-1:0], r_i[CoordW-1:0]};
        end
    end
    assign m_we    = i_cmd.b_wr || i_cmd.clr_wr;
    assign m_waddr = i_cmd.clr_wr ? {jt[CoordW-1:0], ik[CoordW-1:0]}
                                  : {r_j[CoordW-1:0], r_i[CoordW-1:0]};
    assign m_wdata = i_cmd.clr_wr ? '0 : b_code;

    gvfm_ram #(.WIDTH(CodeW), .DEPTH(MaxDim * MaxDim)) u_mask (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    assign o_sts.finished   = r_fin;
    assign o_sts.mask_ready = r_mready;
    assign o_sts.row_end    = r_j >= sv;
    assign o_sts.col_end    = r_i >= su;
    assign o_sts.code_zero  = m_rdata == '0;
    assign o_sts.w_can      = iw < su;
    assign o_sts.code_eq    = m_rdata == r_code;
    assign o_sts.h_can      = jh < sv;
    assign o_sts.k_last     = r_k + DimW'(1) == r_w;
    assign o_sts.clr_last   = (r_k + DimW'(1) == r_w) && (r_t + DimW'(1) == r_h);

    assign mag = r_code[CodeW-1] ? ~r_code[15:0] : r_code[15:0] - 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim[0] <= DimW'(MaxDim);
            r_dim[1] <= DimW'(MaxDim);
            r_dim[2] <= DimW'(MaxDim);
            r_axis   <= '0;
            r_slice  <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_mready <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegDimX: r_dim[0] <= cfg_dim;
                    RegDimY: r_dim[1] <= cfg_dim;
                    RegDimZ: r_dim[2] <= cfg_dim;
                    default: ;
                endcase
            end
            if (restart) begin
                r_axis   <= '0;
                r_slice  <= '0;
                r_row    <= '0;
                r_col    <= '0;
                r_mready <= 1'b0;
                r_fin    <= 1'b0;
            end
            if (i_cmd.mask_done) begin
                r_mready <= 1'b1;
                r_row    <= '0;
                r_col    <= '0;
            end
            if (i_cmd.out_quad) begin
                r_row <= r_j;
                r_col <= iw;
            end
            if (i_cmd.slice_next) begin
                r_mready <= 1'b0;
                if (r_slice + DimW'(1) > sd) begin
                    r_slice <= '0;
                    if (r_axis == 2'd2) begin
                        r_axis <= '0;
                        r_fin  <= 1'b1;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end else begin
                    r_slice <= r_slice + DimW'(1);
                end
            end
        end
    end

    // Working counters and output payload need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.build_init) begin
            r_j <= '0;
            r_i <= '0;
        end
        if (i_cmd.find_init) begin
            r_j <= r_row;
            r_i <= r_col;
        end
        if (i_cmd.b_wr) begin
            if (r_i + DimW'(1) >= su) begin
                r_i <= '0;
                r_j <= r_j + DimW'(1);
            end else begin
                r_i <= r_i + DimW'(1);
            end
        end
        if (i_cmd.row_next) begin
            r_i <= '0;
            r_j <= r_j + DimW'(1);
        end
        if (i_cmd.col_next) begin
            r_i <= r_i + DimW'(1);
        end
        if (i_cmd.hi_rd) begin
            r_lo <= cell_rdata;
        end
        if (i_cmd.code_latch) begin
            r_code <= m_rdata;
            r_w    <= DimW'(1);
        end
        if (i_cmd.w_inc) begin
            r_w <= r_w + DimW'(1);
        end
        if (i_cmd.h_init) begin
            r_h <= DimW'(1);
            r_k <= '0;
        end
        if (i_cmd.h_next_row) begin
            r_h <= r_h + DimW'(1);
            r_k <= '0;
        end
        if (i_cmd.k_inc) begin
            r_k <= r_k + DimW'(1);
        end
        if (i_cmd.clr_init) begin
            r_k <= '0;
            r_t <= '0;
        end
        if (i_cmd.clr_wr) begin
            if (r_k + DimW'(1) == r_w) begin
                r_k <= '0;
                r_t <= r_t + DimW'(1);
            end else begin
                r_k <= r_k + DimW'(1);
            end
        end
        if (i_cmd.out_quad) begin
            o_quad_valid      <= 1'b1;
            o_axis            <= r_axis;
            o_facing_positive <= !r_code[CodeW-1];
            o_slice           <= 6'(r_slice);
            o_start_u         <= 5'(r_i);
            o_start_v         <= 5'(r_j);
            o_width           <= 6'(r_w);
            o_height          <= 6'(r_h);
            o_face_id         <= mag[15:8];
            o_face_shade      <= mag[7:0];
            o_done_res        <= 1'b0;
        end
        if (i_cmd.out_done) begin
            o_quad_valid      <= 1'b0;
            o_axis            <= '0;
            o_facing_positive <= 1'b0;
            o_slice           <= '0;
            o_start_u         <= '0;
            o_start_v         <= '0;
            o_width           <= '0;
            o_height          <= '0;
            o_face_id         <= '0;
            o_face_shade      <= '0;
            o_done_res        <= 1'b1;
        end
    end
endmodule

@@ rtl/gvfm_ctrl.sv @@
// Controller state machine of the mesher: sequences mask build, rectangle search and output.
// Depends on gvfm_pkg.
module gvfm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_command,
    output logic           o_valid,
    input  logic           i_stall,
    input  gvfm_pkg::t_sts i_sts,
    output gvfm_pkg::t_cmd o_cmd
);
    import gvfm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_B_LO  = 4'd2;
    localparam logic [3:0] S_B_HI  = 4'd3;
    localparam logic [3:0] S_B_WR  = 4'd4;
    localparam logic [3:0] S_F_RD  = 4'd5;
    localparam logic [3:0] S_F_CHK = 4'd6;
    localparam logic [3:0] S_W_RD  = 4'd7;
    localparam logic [3:0] S_W_CHK = 4'd8;
    localparam logic [3:0] S_H_RD  = 4'd9;
    localparam logic [3:0] S_H_CHK = 4'd10;
    localparam logic [3:0] S_CLR   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] r_state, n_state;

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_state == S_OUT;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == CmdWrite) begin
                        o_cmd.cell_wr = 1'b1;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.finished) begin
                    o_cmd.out_done = 1'b1;
                    n_state = S_OUT;
                end else if (!i_sts.mask_ready) begin
                    o_cmd.build_init = 1'b1;
                    n_state = S_B_LO;
                end else begin
                    o_cmd.find_init = 1'b1;
                    n_state = S_F_RD;
                end
            end
            S_B_LO: begin
                if (i_sts.row_end) begin
                    o_cmd.mask_done = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    o_cmd.lo_rd = 1'b1;
                    n_state = S_B_HI;
                end
            end
            S_B_HI: begin
                o_cmd.hi_rd = 1'b1;
                n_state = S_B_WR;
            end
            S_B_WR: begin
                o_cmd.b_wr = 1'b1;
                n_state = S_B_LO;
            end
            S_F_RD: begin
                if (i_sts.row_end) begin
                    o_cmd.slice_next = 1'b1;
                    n_state = S_CHECK;
                end else if (i_sts.col_end) begin
                    o_cmd.row_next = 1'b1;
                end else begin
                    o_cmd.f_rd = 1'b1;
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (i_sts.code_zero) begin
                    o_cmd.col_next = 1'b1;
                    n_state = S_F_RD;
                end else begin
                    o_cmd.code_latch = 1'b1;
                    n_state = S_W_RD;
                end
            end
            S_W_RD: begin
                if (i_sts.w_can) begin
                    o_cmd.w_rd = 1'b1;
                    n_state = S_W_CHK;
                end else begin
                    o_cmd.h_init = 1'b1;
                    n_state = S_H_RD;
                end
            end
            S_W_CHK: begin
                if (i_sts.code_eq) begin
                    o_cmd.w_inc = 1'b1;
                    n_state = S_W_RD;
                end else begin
                    o_cmd.h_init = 1'b1;
                    n_state = S_H_RD;
                end
            end
            S_H_RD: begin
                if (i_sts.h_can) begin
                    o_cmd.h_rd = 1'b1;
                    n_state = S_H_CHK;
                end else begin
                    o_cmd.clr_init = 1'b1;
                    n_state = S_CLR;
                end
            end
            S_H_CHK: begin
                if (!i_sts.code_eq) begin
                    o_cmd.clr_init = 1'b1;
                    n_state = S_CLR;
                end else if (i_sts.k_last) begin
                    o_cmd.h_next_row = 1'b1;
                    n_state = S_H_RD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_H_RD;
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.out_quad = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ rtl/greedy_voxel_face_mesher.sv @@
// Greedy voxel face mesher, top level: joins the controller and the datapath.
// Depends on gvfm_pkg, gvfm_ctrl, gvfm_dp and gvfm_ram.
//
// A cell write (command 0) returns nothing. A quad request (command 1)
// returns exactly one result. Each memory has a single read port, so the
// work is serial: a new slice first rebuilds the face mask, with two cell
// store reads and one mask write per in-plane cell; the scan then reads the
// mask cell by cell; a rectangle is grown first along its width and then
// row by row, and its cells are then cleared from the mask one by one. A
// fully empty lattice builds and scans every slice for the final done result.
// Items are handled one at a time; the block stalls its input from the cycle
// after a request until its result is taken.
module greedy_voxel_face_mesher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [5:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_command,
    input  logic [6:0] i_pos_x,
    input  logic [6:0] i_pos_y,
    input  logic [6:0] i_pos_z,
    input  logic       i_cell_solid,
    input  logic [7:0] i_cell_id,
    input  logic [7:0] i_cell_shade,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_quad_valid,
    output logic [1:0] o_axis,
    output logic       o_facing_positive,
    output logic [5:0] o_slice,
    output logic [4:0] o_start_u,
    output logic [4:0] o_start_v,
    output logic [5:0] o_width,
    output logic [5:0] o_height,
    output logic [7:0] o_face_id,
    output logic [7:0] o_face_shade,
    output logic       o_done_res
);
    import gvfm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gvfm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    gvfm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .i_cell_solid      (i_cell_solid),
        .i_cell_id         (i_cell_id),
        .i_cell_shade      (i_cell_shade),
        .o_quad_valid      (o_quad_valid),
        .o_axis            (o_axis),
        .o_facing_positive (o_facing_positive),
        .o_slice           (o_slice),
        .o_start_u         (o_start_u),
        .o_start_v         (o_start_v),
        .o_width           (o_width),
        .o_height          (o_height),
        .o_face_id         (o_face_id),
        .o_face_shade      (o_face_shade),
        .o_done_res        (o_done_res)
    );

    // A pending result keeps the input side closed.
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result is pending");

    a_done_has_no_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> !o_quad_valid)
        else $error("done result carries a quad");

    a_quad_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_quad_valid) |-> (o_width != 6'd0 && o_height != 6'd0))
        else $error("quad with zero extent");

    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_command) |=> o_stall)
        else $error("request did not start work");
endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for greedy_voxel_face_mesher.
// Depends on gvfm_pkg and the mesher RTL; a scoreboard class predicts every quad result.
`timescale 1ns / 1ps

module testbench;
    import gvfm_pkg::*;

    localparam logic [1:0] RegUnused = 2'd3;
    localparam int CycleLimit = 3000000;

    typedef struct {
        bit       quad_valid;
        bit [1:0] axis;
        bit       facing_positive;
        bit [5:0] slice;
        bit [4:0] start_u;
        bit [4:0] start_v;
        bit [5:0] width;
        bit [5:0] height;
        bit [7:0] face_id;
        bit [7:0] face_shade;
        bit       done_res;
    } t_quad;

    class face_scoreboard;
        t_quad       pending_quads[$];
        logic [16:0] cells[int];
        int          mask[1024];
        int          dim[3];
        int          s_axis, s_slice, s_row, s_col;
        bit          mask_ready, finished;
        int          errors;

        function new();
            dim = '{32, 32, 32};
            errors = 0;
            foreach (mask[i]) mask[i] = 0;
            restart();
        endfunction

        function void restart();
            s_axis = 0;
            s_slice = 0;
            s_row = 0;
            s_col = 0;
            mask_ready = 0;
            finished = 0;
        endfunction

        function void queue_result(t_quad r);
            pending_quads = {pending_quads, r};
        endfunction

        function int addr(int x, int y, int z);
            return ((x + 1) * Side + (y + 1)) * Side + (z + 1);
        endfunction

        function bit written(int x, int y, int z);
            return cells.exists(addr(x, y, z));
        endfunction

        // Cell at depth a along axis d, b along u, c along v.
        function logic [16:0] cell_at(int d, int a, int b, int c);
            int p[3];
            int idx;
            p[d] = a;
            p[(d + 1) % 3] = b;
            p[(d + 2) % 3] = c;
            for (int k = 0; k < 3; k++)
                if (p[k] < -1 || p[k] > MaxDim) return 17'd0;
            idx = addr(p[0], p[1], p[2]);
            return cells.exists(idx) ? cells[idx] : 17'd0;
        endfunction

        function void set_dim(int idx, int value);
            int v;
            if (idx > 2) return;
            v = value & 63;
            if (v < 1) v = 1;
            if (v > MaxDim) v = MaxDim;
            dim[idx] = v;
            restart();
        endfunction

        function void build_mask();
            int su, sv, sd, code;
            logic [16:0] lo, hi;
            su = dim[(s_axis + 1) % 3];
            sv = dim[(s_axis + 2) % 3];
            sd = dim[s_axis];
            for (int j = 0; j < sv; j++) begin
                for (int i = 0; i < su; i++) begin
                    lo = cell_at(s_axis, s_slice - 1, i, j);
                    hi = cell_at(s_axis, s_slice, i, j);
                    code = 0;
                    if (lo[16] && !hi[16] && s_slice >= 1)
                        code = int'(lo[15:0]) + 1;
                    else if (hi[16] && !lo[16] && s_slice < sd)
                        code = -(int'(hi[15:0]) + 1);
                    mask[j * su + i] = code;
                end
            end
            s_row = 0;
            s_col = 0;
            mask_ready = 1;
        endfunction

        function bit find_quad(output t_quad r);
            int su, sv, code, w, h, mag;
            bit grow;
            su = dim[(s_axis + 1) % 3];
            sv = dim[(s_axis + 2) % 3];
            r = '{default: 0};
            for (int j = s_row; j < sv; j++) begin
                for (int i = (j == s_row) ? s_col : 0; i < su; i++) begin
                    code = mask[j * su + i];
                    if (code != 0) begin
                        w = 1;
                        while (i + w < su && mask[j * su + i + w] == code) w++;
                        h = 1;
                        grow = 1;
                        while (j + h < sv && grow) begin
                            for (int k = 0; k < w; k++)
                                if (mask[(j + h) * su + i + k] != code) grow = 0;
                            if (grow) h++;
                        end
                        for (int jj = 0; jj < h; jj++)
                            for (int k = 0; k < w; k++)
                                mask[(j + jj) * su + i + k] = 0;
                        mag = (code > 0 ? code : -code) - 1;
                        r.quad_valid = 1;
                        r.axis = s_axis;
                        r.facing_positive = code > 0;
                        r.slice = s_slice;
                        r.start_u = i;
                        r.start_v = j;
                        r.width = w;
                        r.height = h;
                        r.face_id = mag[15:8];
                        r.face_shade = mag[7:0];
                        s_row = j;
                        s_col = i + w;
                        return 1;
                    end
                end
            end
            s_row = sv;
            s_col = 0;
            return 0;
        endfunction

        function void note(bit cmd, logic [6:0] px, logic [6:0] py, logic [6:0] pz,
                           bit solid, logic [7:0] id, logic [7:0] shade);
            int x, y, z;
            t_quad r;
            if (cmd == CmdWrite) begin
                x = $signed(px);
                y = $signed(py);
                z = $signed(pz);
                if (x >= -1 && x <= MaxDim && y >= -1 && y <= MaxDim &&
                    z >= -1 && z <= MaxDim)
                    cells[addr(x, y, z)] = {solid, id, shade};
                restart();
                return;
            end
            while (!finished) begin
                if (!mask_ready) build_mask();
                if (find_quad(r)) begin
                    queue_result(r);
                    return;
                end
                mask_ready = 0;
                s_slice++;
                if (s_slice > dim[s_axis]) begin
                    s_slice = 0;
                    s_axis++;
                    if (s_axis >= 3) begin
                        s_axis = 0;
                        finished = 1;
                    end
                end
            end
            r = '{default: 0};
            r.done_res = 1;
            queue_result(r);
        endfunction

        function void cmp(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(t_quad got);
            t_quad e;
            if (pending_quads.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending_quads.pop_front();
            cmp("quad_valid", e.quad_valid, got.quad_valid);
            cmp("axis", e.axis, got.axis);
            cmp("facing_positive", e.facing_positive, got.facing_positive);
            cmp("slice", e.slice, got.slice);
            cmp("start_u", e.start_u, got.start_u);
            cmp("start_v", e.start_v, got.start_v);
            cmp("width", e.width, got.width);
            cmp("height", e.height, got.height);
            cmp("face_id", e.face_id, got.face_id);
            cmp("face_shade", e.face_shade, got.face_shade);
            cmp("done_res", e.done_res, got.done_res);
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_cfg_we = 0;
    logic [1:0] i_cfg_index = '0;
    logic [5:0] i_cfg_data = '0;
    logic       i_valid = 0;
    logic       o_stall;
    logic       i_command = 0;
    logic [6:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic       i_cell_solid = 0;
    logic [7:0] i_cell_id = '0, i_cell_shade = '0;
    logic       o_valid;
    logic       i_stall = 0;
    logic       o_quad_valid, o_facing_positive, o_done_res;
    logic [1:0] o_axis;
    logic [5:0] o_slice, o_width, o_height;
    logic [4:0] o_start_u, o_start_v;
    logic [7:0] o_face_id, o_face_shade;

    greedy_voxel_face_mesher u_top (.*);

    face_scoreboard sb = new();
    int cycles = 0;
    int hold_req = 0;
    int n_items = 0;
    int burst_left = 0;
    logic [7:0] pal_id[2];
    logic [7:0] pal_shade[2];

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_quad got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.quad_valid = o_quad_valid;
            got.axis = o_axis;
            got.facing_positive = o_facing_positive;
            got.slice = o_slice;
            got.start_u = o_start_u;
            got.start_v = o_start_v;
            got.width = o_width;
            got.height = o_height;
            got.face_id = o_face_id;
            got.face_shade = o_face_shade;
            got.done_res = o_done_res;
            sb.check(got);
        end
    end

    // Receiver back-pressure: switches between open, random and periodic
    // patterns, and holds off for a long stretch when asked.
    initial begin
        int mode, mode_left, hold_seen, hold_left, tick;
        mode = 0;
        mode_left = 100;
        hold_seen = 0;
        hold_left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 400;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(64, 512);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_stall = 1;
            end else if (mode == 1)
                i_stall = $urandom_range(0, 99) < 40;
            else if (mode == 2)
                i_stall = (tick % 4) == 0;
            else
                i_stall = 0;
        end
    end

    task automatic send(bit cmd, int x, int y, int z, bit solid,
                        logic [7:0] id, logic [7:0] shade);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                @(negedge i_clk);
                i_valid = 0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid = 1;
        i_command = cmd;
        i_pos_x = 7'(x);
        i_pos_y = 7'(y);
        i_pos_z = 7'(z);
        i_cell_solid = solid;
        i_cell_id = id;
        i_cell_shade = shade;
        do @(posedge i_clk); while (o_stall);
        sb.note(cmd, i_pos_x, i_pos_y, i_pos_z, solid, id, shade);
        n_items++;
    endtask

    task automatic request_quad();
        send(CmdRequest, $urandom_range(0, 127), $urandom_range(0, 127),
             $urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 255),
             $urandom_range(0, 255));
    endtask

    task automatic write_random_cell(int x, int y, int z);
        logic [7:0] id, shade;
        if ($urandom_range(0, 7) == 0) begin
            id = $urandom_range(0, 255);
            shade = $urandom_range(0, 255);
        end else begin
            id = pal_id[$urandom_range(0, 1)];
            shade = pal_shade[$urandom_range(0, 1)];
        end
        send(CmdWrite, x, y, z, $urandom_range(0, 99) < 45, id, shade);
    endtask

    // Write every cell that a scan at the current sizes can read.
    task automatic fill_lattice(bit rewrite);
        int dx, dy, dz, border;
        dx = sb.dim[0];
        dy = sb.dim[1];
        dz = sb.dim[2];
        for (int x = -1; x <= dx; x++)
            for (int y = -1; y <= dy; y++)
                for (int z = -1; z <= dz; z++) begin
                    border = (x < 0 || x >= dx) + (y < 0 || y >= dy) + (z < 0 || z >= dz);
                    if (border <= 1 && (rewrite || !sb.written(x, y, z)))
                        write_random_cell(x, y, z);
                end
    endtask

    // Wait until the block is idle before touching a register.
    task automatic settle();
        @(negedge i_clk);
        i_valid = 0;
        burst_left = 0;
        while (sb.pending_quads.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [5:0] value);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_data = value;
        sb.set_dim(idx, value);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic set_sizes(int dx, int dy, int dz);
        settle();
        set_reg(RegDimX, dx);
        set_reg(RegDimY, dy);
        set_reg(RegDimZ, dz);
        if ($urandom_range(0, 3) == 0) set_reg(RegUnused, $urandom_range(0, 63));
    endtask

    // Requests until the scan is exhausted or max_req is reached, odd writes mixed in,
    // then one or two more; any write restarts the scan, a wild one being dropped.
    task automatic run_scan(int max_req, int write_pct);
        int k;
        k = 0;
        while (!sb.finished && k < max_req) begin
            if ($urandom_range(0, 99) < write_pct) begin
                if ($urandom_range(0, 3) == 0)
                    send(CmdWrite, $signed(7'($urandom_range(0, 127))),
                         $signed(7'($urandom_range(0, 127))),
                         $signed(7'($urandom_range(0, 127))), $urandom_range(0, 1),
                         $urandom_range(0, 255), $urandom_range(0, 255));
                else
                    write_random_cell($urandom_range(0, sb.dim[0] + 1) - 1,
                                      $urandom_range(0, sb.dim[1] + 1) - 1,
                                      $urandom_range(0, sb.dim[2] + 1) - 1);
            end else
                request_quad();
            k++;
        end
        repeat ($urandom_range(1, 2)) begin
            request_quad();
        end
    endtask

    initial begin
        int pick;
        pal_id = '{8'h00, 8'hFF};
        pal_shade = '{8'hFF, 8'h00};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: smallest lattice, extreme data, dropped writes, exhausted scan.
        set_reg(RegDimX, 6'd0);
        set_reg(RegDimY, 6'd0);
        set_reg(RegDimZ, 6'd0);
        set_reg(RegUnused, 6'd63);
        fill_lattice(1);
        send(CmdWrite, 0, 0, 0, 1, 8'hFF, 8'hFF);
        send(CmdWrite, 1, 0, 0, 1, 8'h00, 8'h00);
        send(CmdWrite, -1, 0, 0, 0, 8'hFF, 8'hFF);
        send(CmdWrite, 33, 0, 0, 1, 8'h12, 8'h34);
        send(CmdWrite, -2, -64, 63, 1, 8'h56, 8'h78);
        run_scan(20, 0);
        send(CmdWrite, 0, 0, 0, 0, 8'hAA, 8'h55);
        run_scan(20, 0);

        // Oversized register value clamps to the largest size along x; the other
        // axes stay thin so that the whole scan fits in the item budget.
        set_sizes(63, 2, 1);
        fill_lattice(1);
        run_scan(300, 0);

        while (n_items < 950) begin
            pal_id = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
            pal_shade = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 3))};
            pick = $urandom_range(0, 9);
            if (pick == 0)
                set_sizes(1, $urandom_range(1, 5), 1);
            else if (pick == 1)
                set_sizes($urandom_range(4, 6), $urandom_range(1, 2), $urandom_range(3, 6));
            else
                set_sizes($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4));
            fill_lattice(1);
            if (hold_req == 0) hold_req++;
            run_scan(300, $urandom_range(0, 1) ? 0 : 6);
        end

        @(negedge i_clk);
        i_valid = 0;
        while (sb.pending_quads.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ greedy_voxel_face_mesher.f @@
rtl/gvfm_pkg.sv
rtl/gvfm_ram.sv
rtl/gvfm_dp.sv
rtl/gvfm_ctrl.sv
rtl/greedy_voxel_face_mesher.sv
sim/testbench.sv
